### rtl/fwfb_pkg.sv
package fwfb_pkg;

    // chunking
    localparam int CHUNK_BYTES  = 128;
    localparam int LEN_W        = 8;
    localparam int LEN_OVERHEAD = 10;

    // stream widths
    localparam int BYTE_W      = 8;
    localparam int OUTCOME_W   = 3;
    localparam int COUNT_W     = 24;
    localparam int ADDR_W      = 32;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_LENGTH  = 3'd0,
        REG_BASE_ADDRESS  = 3'd1,
        REG_WRITE_OPCODE  = 3'd2,
        REG_ACK_CODE      = 3'd3,
        REG_NACK_CODE     = 3'd4,
        REG_WRITE_FAILED  = 3'd5
    } t_reg_idx;

    localparam logic [ADDR_W-1:0]  BASE_ADDRESS_RST = 32'h0800_4000;

    // input opcode and result kind
    localparam logic OP_IMAGE = 1'b0;
    localparam logic OP_REPLY = 1'b1;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_NONE     = 3'd0,
        OUT_WRITTEN  = 3'd1,
        OUT_NACK     = 3'd2,
        OUT_WFAIL    = 3'd3,
        OUT_COMPLETE = 3'd4,
        OUT_IGNORED  = 3'd5
    } t_outcome;

    typedef enum logic [1:0] {
        CMD_DATA   = 2'd0,
        CMD_REPLY  = 2'd1,
        CMD_IGNORE = 2'd2
    } t_cmd_kind;

    // one classified input, front to back
    typedef struct packed {
        t_cmd_kind          kind;
        logic               op;
        logic [BYTE_W-1:0]  data;
        t_outcome           outcome;
        logic               first;
        logic               last;
        logic [LEN_W-1:0]   len;
        logic [ADDR_W-1:0]  addr;
    } t_cmd;

    localparam int CMD_W       = $bits(t_cmd);
    localparam int QUEUE_DEPTH = 2;

    // settled configuration values
    typedef struct packed {
        logic [COUNT_W-1:0] image_length;
        logic [ADDR_W-1:0]  base_address;
        logic [BYTE_W-1:0]  write_opcode;
        logic [BYTE_W-1:0]  ack_code;
        logic [BYTE_W-1:0]  nack_code;
        logic [BYTE_W-1:0]  write_failed_code;
    } t_cfg;

    // configuration write events for the front
    typedef struct packed {
        logic               restart;
        logic               base_wr;
        logic [ADDR_W-1:0]  base_value;
    } t_cfg_evt;

    // frame beat sequence
    localparam int STEP_W       = 4;
    localparam logic [STEP_W-1:0] STEP_LEN     = 4'd0;
    localparam logic [STEP_W-1:0] STEP_OPCODE  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_ADDR0   = 4'd2;
    localparam logic [STEP_W-1:0] STEP_ADDR1   = 4'd3;
    localparam logic [STEP_W-1:0] STEP_ADDR2   = 4'd4;
    localparam logic [STEP_W-1:0] STEP_ADDR3   = 4'd5;
    localparam logic [STEP_W-1:0] STEP_CLEN    = 4'd6;
    localparam logic [STEP_W-1:0] STEP_PAYLOAD = 4'd7;
    localparam logic [STEP_W-1:0] STEP_CRC0    = 4'd8;
    localparam logic [STEP_W-1:0] STEP_CRC1    = 4'd9;
    localparam logic [STEP_W-1:0] STEP_CRC2    = 4'd10;
    localparam logic [STEP_W-1:0] STEP_CRC3    = 4'd11;

    // crc
    localparam int CRC_W = 32;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 32'h04C1_1DB7;

    typedef logic [CRC_W-1:0][CRC_W-1:0] t_crc_mat;

    // row j holds the input bits that feed output bit j after 32 shifts
    function automatic t_crc_mat crc_matrix();
        t_crc_mat m;
        logic [CRC_W-1:0] v;
        for (int i = 0; i < CRC_W; i++) begin
            v = CRC_W'(1) << i;
            for (int k = 0; k < CRC_W; k++) begin
                v = v[CRC_W-1] ? ((v << 1) ^ CRC_POLY) : (v << 1);
            end
            for (int j = 0; j < CRC_W; j++) begin
                m[j][i] = v[j];
            end
        end
        return m;
    endfunction

    localparam t_crc_mat CRC_MAT = crc_matrix();

    // one byte step: flat xor network, one parity per output bit
    function automatic logic [CRC_W-1:0] crc_advance(input logic [CRC_W-1:0] x);
        logic [CRC_W-1:0] y;
        for (int j = 0; j < CRC_W; j++) begin
            y[j] = ^(x & CRC_MAT[j]);
        end
        return y;
    endfunction

endpackage

### rtl/flash_write_frame_builder.sv
// channel   dir  handshake                   payload
// s_axis    in   s_axis_tvalid/s_axis_tready tuser: opcode
//                                            tdata: image_byte, reply_code, write_status
// m_axis    out  m_axis_tvalid/m_axis_tready tuser: result_kind, tlast: last_of_run
//                                            tdata: frame_byte, outcome
// cfg       in   i_cfg_we (no wait)          i_cfg_index, i_cfg_data
//
// one result beat per clock while commands are queued and m_axis_tready allows; an
// input beat is taken every clock while the two-entry command queue has room. a
// middle payload byte gives only its payload beat, the first byte of a chunk also
// the header beats before it, the last byte also the crc beats after it
// synchronous active-low reset: no frame open, registers at reset values
// while m_axis_tready is low the front end fills the queue, then drops s_axis_tready
module flash_write_frame_builder (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration writes
    input  logic                               i_cfg_we,
    input  logic [fwfb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fwfb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [fwfb_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // image_byte, reply_code, write_status
    input  logic                               s_axis_tuser,  // opcode
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [fwfb_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // frame_byte, outcome, zero pad
    output logic                               m_axis_tuser,  // result_kind
    output logic                               m_axis_tlast   // last_of_run
);

    fwfb_pkg::t_cfg      r_cfg;
    fwfb_pkg::t_cfg_evt  cfg_evt;
    fwfb_pkg::t_cmd      front_cmd;
    fwfb_pkg::t_cmd      head_cmd;

    logic                               front_push;
    logic                               queue_full;
    logic                               head_valid;
    logic                               head_pop;
    logic [fwfb_pkg::BYTE_W-1:0]        out_byte;
    logic [fwfb_pkg::OUTCOME_W-1:0]     out_outcome;

    // register file, one write per enabled clock
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_length      <= '0;
            r_cfg.base_address      <= fwfb_pkg::BASE_ADDRESS_RST;
            r_cfg.write_opcode      <= '0;
            r_cfg.ack_code          <= '0;
            r_cfg.nack_code         <= '0;
            r_cfg.write_failed_code <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fwfb_pkg::REG_IMAGE_LENGTH:
                    r_cfg.image_length <= i_cfg_data[fwfb_pkg::COUNT_W-1:0];
                fwfb_pkg::REG_BASE_ADDRESS:
                    r_cfg.base_address <= i_cfg_data[fwfb_pkg::ADDR_W-1:0];
                fwfb_pkg::REG_WRITE_OPCODE:
                    r_cfg.write_opcode <= i_cfg_data[fwfb_pkg::BYTE_W-1:0];
                fwfb_pkg::REG_ACK_CODE:
                    r_cfg.ack_code <= i_cfg_data[fwfb_pkg::BYTE_W-1:0];
                fwfb_pkg::REG_NACK_CODE:
                    r_cfg.nack_code <= i_cfg_data[fwfb_pkg::BYTE_W-1:0];
                fwfb_pkg::REG_WRITE_FAILED:
                    r_cfg.write_failed_code <= i_cfg_data[fwfb_pkg::BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // image_length write restarts the transfer, base_address may reload the pointer
    assign cfg_evt.restart    = i_cfg_we && (i_cfg_index == fwfb_pkg::REG_IMAGE_LENGTH);
    assign cfg_evt.base_wr    = i_cfg_we && (i_cfg_index == fwfb_pkg::REG_BASE_ADDRESS);
    assign cfg_evt.base_value = i_cfg_data[fwfb_pkg::ADDR_W-1:0];

    // front: classify each beat and keep the chunk bookkeeping
    fwfb_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_evt          (cfg_evt),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_op           (s_axis_tuser),
        .i_image_byte   (s_axis_tdata[7:0]),
        .i_reply_code   (s_axis_tdata[15:8]),
        .i_write_status (s_axis_tdata[23:16]),
        .o_push         (front_push),
        .o_cmd          (front_cmd),
        .i_full         (queue_full)
    );

    // short command queue decoupling the two halves
    fwfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_full  (queue_full),
        .i_pop   (head_pop),
        .o_valid (head_valid),
        .o_cmd   (head_cmd)
    );

    // back: expand commands into frame beats and run the crc
    fwfb_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_write_opcode (r_cfg.write_opcode),
        .i_valid        (head_valid),
        .i_cmd          (head_cmd),
        .o_pop          (head_pop),
        .o_tvalid       (m_axis_tvalid),
        .i_tready       (m_axis_tready),
        .o_kind         (m_axis_tuser),
        .o_byte         (out_byte),
        .o_last         (m_axis_tlast),
        .o_outcome      (out_outcome)
    );

    assign m_axis_tdata = {
        {(fwfb_pkg::OUT_TDATA_W - fwfb_pkg::BYTE_W - fwfb_pkg::OUTCOME_W){1'b0}},
        out_outcome,
        out_byte
    };

endmodule

### rtl/fwfb_front.sv
module fwfb_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fwfb_pkg::t_cfg                i_cfg,
    input  fwfb_pkg::t_cfg_evt            i_evt,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_op,
    input  logic [fwfb_pkg::BYTE_W-1:0]   i_image_byte,
    input  logic [fwfb_pkg::BYTE_W-1:0]   i_reply_code,
    input  logic [fwfb_pkg::BYTE_W-1:0]   i_write_status,
    output logic                          o_push,
    output fwfb_pkg::t_cmd                o_cmd,
    input  logic                          i_full
);

    logic [fwfb_pkg::COUNT_W-1:0] r_bytes_sent, n_bytes_sent;
    logic [fwfb_pkg::LEN_W-1:0]   r_pos, n_pos;
    logic [fwfb_pkg::LEN_W-1:0]   r_len, n_len;
    logic [fwfb_pkg::ADDR_W-1:0]  r_next_addr, n_next_addr;
    logic                         r_aborted, n_aborted;

    logic                         accept;
    logic                         awaiting;
    logic                         all_sent;
    logic                         first;
    logic                         last;
    logic [fwfb_pkg::COUNT_W-1:0] remaining;
    logic [fwfb_pkg::LEN_W-1:0]   new_len;
    logic [fwfb_pkg::LEN_W-1:0]   len_eff;
    logic [fwfb_pkg::LEN_W-1:0]   pos_inc;

    assign o_ready  = !i_full;
    assign accept   = i_valid && !i_full;
    assign o_push   = accept;

    assign awaiting  = (r_len != '0) && (r_pos == r_len);
    assign all_sent  = r_bytes_sent >= i_cfg.image_length;
    assign remaining = i_cfg.image_length - r_bytes_sent;
    assign new_len   = (remaining >= fwfb_pkg::COUNT_W'(fwfb_pkg::CHUNK_BYTES))
                       ? fwfb_pkg::LEN_W'(fwfb_pkg::CHUNK_BYTES)
                       : remaining[fwfb_pkg::LEN_W-1:0];
    assign first     = (r_len == '0);
    assign len_eff   = first ? new_len : r_len;
    assign pos_inc   = (first ? '0 : r_pos) + fwfb_pkg::LEN_W'(1);
    assign last      = (pos_inc == len_eff);

    always_comb begin
        n_bytes_sent = r_bytes_sent;
        n_pos        = r_pos;
        n_len        = r_len;
        n_next_addr  = r_next_addr;
        n_aborted    = r_aborted;

        o_cmd.kind    = fwfb_pkg::CMD_IGNORE;
        o_cmd.op      = i_op;
        o_cmd.data    = i_image_byte;
        o_cmd.outcome = fwfb_pkg::OUT_IGNORED;
        o_cmd.first   = first;
        o_cmd.last    = last;
        o_cmd.len     = len_eff;
        o_cmd.addr    = r_next_addr;

        if (i_op == fwfb_pkg::OP_IMAGE) begin
            if (!(r_aborted || awaiting || all_sent)) begin
                o_cmd.kind    = fwfb_pkg::CMD_DATA;
                o_cmd.outcome = fwfb_pkg::OUT_NONE;
                n_len         = len_eff;
                n_pos         = pos_inc;
                n_bytes_sent  = r_bytes_sent + fwfb_pkg::COUNT_W'(1);
                if (last) begin
                    n_next_addr = r_next_addr + fwfb_pkg::ADDR_W'(len_eff);
                end
            end
        end else if (!r_aborted && awaiting) begin
            o_cmd.kind = fwfb_pkg::CMD_REPLY;
            n_len      = '0;
            n_pos      = '0;
            if (i_reply_code == i_cfg.ack_code) begin
                if (i_write_status == i_cfg.write_failed_code) begin
                    n_aborted     = 1'b1;
                    o_cmd.outcome = fwfb_pkg::OUT_WFAIL;
                end else begin
                    o_cmd.outcome = all_sent ? fwfb_pkg::OUT_COMPLETE
                                             : fwfb_pkg::OUT_WRITTEN;
                end
            end else if (i_reply_code == i_cfg.nack_code) begin
                n_aborted     = 1'b1;
                o_cmd.outcome = fwfb_pkg::OUT_NACK;
            end else begin
                o_cmd.outcome = fwfb_pkg::OUT_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_sent <= '0;
            r_pos        <= '0;
            r_len        <= '0;
            r_next_addr  <= fwfb_pkg::BASE_ADDRESS_RST;
            r_aborted    <= 1'b0;
        end else if (i_evt.restart) begin
            r_bytes_sent <= '0;
            r_pos        <= '0;
            r_len        <= '0;
            r_next_addr  <= i_cfg.base_address;
            r_aborted    <= 1'b0;
        end else if (i_evt.base_wr) begin
            // only reload while no transfer is under way
            if (r_bytes_sent == '0 && r_len == '0) begin
                r_next_addr <= i_evt.base_value;
            end
        end else if (accept) begin
            r_bytes_sent <= n_bytes_sent;
            r_pos        <= n_pos;
            r_len        <= n_len;
            r_next_addr  <= n_next_addr;
            r_aborted    <= n_aborted;
        end
    end

endmodule

### rtl/fwfb_queue.sv
module fwfb_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fwfb_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output fwfb_pkg::t_cmd o_cmd
);

    localparam int PTR_W = $clog2(fwfb_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(fwfb_pkg::QUEUE_DEPTH + 1);

    fwfb_pkg::t_cmd   r_mem [fwfb_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNT_W'(fwfb_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(fwfb_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(fwfb_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

### rtl/fwfb_back.sv
module fwfb_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [fwfb_pkg::BYTE_W-1:0]      i_write_opcode,
    input  logic                             i_valid,
    input  fwfb_pkg::t_cmd                   i_cmd,
    output logic                             o_pop,
    output logic                             o_tvalid,
    input  logic                             i_tready,
    output logic                             o_kind,
    output logic [fwfb_pkg::BYTE_W-1:0]      o_byte,
    output logic                             o_last,
    output logic [fwfb_pkg::OUTCOME_W-1:0]   o_outcome
);

    logic                              r_tvalid;
    logic                              r_kind;
    logic [fwfb_pkg::BYTE_W-1:0]       r_byte;
    logic                              r_last;
    logic [fwfb_pkg::OUTCOME_W-1:0]    r_outcome;
    logic [fwfb_pkg::CRC_W-1:0]        r_crc;
    logic [fwfb_pkg::STEP_W-1:0]       r_step;
    logic                              r_active;

    logic                              emit;
    logic                              is_data;
    logic                              final_beat;
    logic [fwfb_pkg::STEP_W-1:0]       step;
    logic [fwfb_pkg::BYTE_W-1:0]       beat_byte;
    logic [fwfb_pkg::LEN_W-1:0]        frame_len;
    logic [fwfb_pkg::CRC_W-1:0]        crc_base;
    logic [fwfb_pkg::CRC_W-1:0]        n_crc;

    assign emit      = i_valid && (!r_tvalid || i_tready);
    assign is_data   = (i_cmd.kind == fwfb_pkg::CMD_DATA);
    assign step      = r_active ? r_step
                       : (i_cmd.first ? fwfb_pkg::STEP_LEN : fwfb_pkg::STEP_PAYLOAD);
    assign frame_len = i_cmd.len + fwfb_pkg::LEN_W'(fwfb_pkg::LEN_OVERHEAD);

    assign final_beat = !is_data
                        || (step == fwfb_pkg::STEP_PAYLOAD && !i_cmd.last)
                        || (step == fwfb_pkg::STEP_CRC3);
    assign o_pop = emit && final_beat;

    always_comb begin
        unique case (step)
            fwfb_pkg::STEP_LEN:     beat_byte = frame_len;
            fwfb_pkg::STEP_OPCODE:  beat_byte = i_write_opcode;
            fwfb_pkg::STEP_ADDR0:   beat_byte = i_cmd.addr[7:0];
            fwfb_pkg::STEP_ADDR1:   beat_byte = i_cmd.addr[15:8];
            fwfb_pkg::STEP_ADDR2:   beat_byte = i_cmd.addr[23:16];
            fwfb_pkg::STEP_ADDR3:   beat_byte = i_cmd.addr[31:24];
            fwfb_pkg::STEP_CLEN:    beat_byte = i_cmd.len;
            fwfb_pkg::STEP_PAYLOAD: beat_byte = i_cmd.data;
            fwfb_pkg::STEP_CRC0:    beat_byte = r_crc[7:0];
            fwfb_pkg::STEP_CRC1:    beat_byte = r_crc[15:8];
            fwfb_pkg::STEP_CRC2:    beat_byte = r_crc[23:16];
            fwfb_pkg::STEP_CRC3:    beat_byte = r_crc[31:24];
            default:                beat_byte = '0;
        endcase
    end

    // crc restarts on the length byte of every frame
    assign crc_base = (step == fwfb_pkg::STEP_LEN) ? fwfb_pkg::CRC_INIT : r_crc;
    assign n_crc    = fwfb_pkg::crc_advance(
                          crc_base ^ fwfb_pkg::CRC_W'(beat_byte));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= 1'b0;
            r_active <= 1'b0;
            r_step   <= '0;
        end else begin
            if (emit) begin
                r_tvalid <= 1'b1;
            end else if (i_tready) begin
                r_tvalid <= 1'b0;
            end
            if (emit) begin
                r_active <= !final_beat;
                r_step   <= step + fwfb_pkg::STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind    <= is_data ? fwfb_pkg::OP_IMAGE
                                 : ((i_cmd.kind == fwfb_pkg::CMD_REPLY)
                                    ? fwfb_pkg::OP_REPLY : i_cmd.op);
            r_byte    <= is_data ? beat_byte : '0;
            r_last    <= final_beat;
            r_outcome <= i_cmd.outcome;
            if (is_data && step <= fwfb_pkg::STEP_PAYLOAD) begin
                r_crc <= n_crc;
            end
        end
    end

    assign o_tvalid  = r_tvalid;
    assign o_kind    = r_kind;
    assign o_byte    = r_byte;
    assign o_last    = r_last;
    assign o_outcome = r_outcome;

endmodule

### tb/fwfb_checker.sv
`timescale 1ns / 1ps

module fwfb_checker
    import fwfb_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // image_byte, reply_code, write_status
    input  logic                   s_axis_tuser,   // opcode
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,   // frame_byte, outcome, zero pad
    input  logic                   m_axis_tuser,   // result_kind
    input  logic                   m_axis_tlast,   // last_of_run
    output int                     o_fail_count,
    output int                     o_pending
);

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] fbyte;
        logic              last;
        t_outcome          outcome;
    } t_frame_result;

    t_frame_result owed_results[$];
    t_frame_result seen, want;

    // register copies
    logic [COUNT_W-1:0] image_len;
    logic [ADDR_W-1:0]  base_addr;
    logic [BYTE_W-1:0]  wr_opcode;
    logic [BYTE_W-1:0]  ack_code;
    logic [BYTE_W-1:0]  nack_code;
    logic [BYTE_W-1:0]  wfail_code;

    // frame builder state
    logic [CRC_W-1:0]   crc;
    logic [COUNT_W-1:0] sent;
    logic [LEN_W-1:0]   pos;
    logic [LEN_W-1:0]   clen;
    logic [ADDR_W-1:0]  next_addr;
    logic               aborted;

    // 32 msb-first shifts per byte, byte xored into the low end
    function automatic logic [CRC_W-1:0] crc_after_byte(input logic [CRC_W-1:0] c,
                                                       input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] r;
        r = c ^ CRC_W'(b);
        for (int i = 0; i < CRC_W; i++) begin
            r = r[CRC_W-1] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

    task automatic restart_image();
        crc       = CRC_INIT;
        sent      = '0;
        pos       = '0;
        clen      = '0;
        next_addr = base_addr;
        aborted   = 1'b0;
    endtask

    task automatic owe(input logic kind, input logic [BYTE_W-1:0] b, input logic last,
                       input t_outcome oc);
        owed_results.push_back(t_frame_result'{kind, b, last, oc});
    endtask

    task automatic owe_frame_byte(input logic [BYTE_W-1:0] b, input logic last);
        owe(OP_IMAGE, b, last, OUT_NONE);
        crc = crc_after_byte(crc, b);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_IMAGE_LENGTH: begin
                image_len = val[COUNT_W-1:0];
                restart_image();
            end
            REG_BASE_ADDRESS: begin
                base_addr = val[ADDR_W-1:0];
                if (sent == '0 && clen == '0) next_addr = base_addr;
            end
            REG_WRITE_OPCODE: wr_opcode  = val[BYTE_W-1:0];
            REG_ACK_CODE:     ack_code   = val[BYTE_W-1:0];
            REG_NACK_CODE:    nack_code  = val[BYTE_W-1:0];
            REG_WRITE_FAILED: wfail_code = val[BYTE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic build_frame_results(input logic op, input logic [BYTE_W-1:0] data,
                                       input logic [BYTE_W-1:0] reply,
                                       input logic [BYTE_W-1:0] status);
        logic               awaiting;
        logic               closes;
        logic [COUNT_W-1:0] rem;
        logic [CRC_W-1:0]   fcs;
        awaiting = (clen != '0) && (pos == clen);
        if (op == OP_IMAGE) begin
            if (aborted || awaiting || sent >= image_len) begin
                owe(OP_IMAGE, '0, 1'b1, OUT_IGNORED);
            end else begin
                if (clen == '0) begin
                    rem  = image_len - sent;
                    clen = (rem >= COUNT_W'(CHUNK_BYTES)) ? LEN_W'(CHUNK_BYTES)
                                                          : rem[LEN_W-1:0];
                    pos  = '0;
                    crc  = CRC_INIT;
                    owe_frame_byte(clen + LEN_W'(LEN_OVERHEAD), 1'b0);
                    owe_frame_byte(wr_opcode, 1'b0);
                    for (int i = 0; i < 4; i++) begin
                        owe_frame_byte(next_addr[8*i +: 8], 1'b0);
                    end
                    owe_frame_byte(clen, 1'b0);
                end
                pos    = pos + LEN_W'(1);
                sent   = sent + COUNT_W'(1);
                closes = (pos == clen);
                owe_frame_byte(data, !closes);
                if (closes) begin
                    fcs = crc;
                    for (int i = 0; i < 4; i++) begin
                        owe(OP_IMAGE, fcs[8*i +: 8], i == 3, OUT_NONE);
                    end
                    next_addr = next_addr + ADDR_W'(clen);
                end
            end
        end else if (aborted || !awaiting) begin
            owe(OP_REPLY, '0, 1'b1, OUT_IGNORED);
        end else begin
            clen = '0;
            pos  = '0;
            if (reply == ack_code) begin
                if (status == wfail_code) begin
                    aborted = 1'b1;
                    owe(OP_REPLY, '0, 1'b1, OUT_WFAIL);
                end else begin
                    owe(OP_REPLY, '0, 1'b1,
                        (sent >= image_len) ? OUT_COMPLETE : OUT_WRITTEN);
                end
            end else if (reply == nack_code) begin
                aborted = 1'b1;
                owe(OP_REPLY, '0, 1'b1, OUT_NACK);
            end else begin
                owe(OP_REPLY, '0, 1'b1, OUT_NONE);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            image_len  = '0;
            base_addr  = BASE_ADDRESS_RST;
            wr_opcode  = '0;
            ack_code   = '0;
            nack_code  = '0;
            wfail_code = '0;
            restart_image();
            owed_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) write_register(i_cfg_index, i_cfg_data);
            if (s_axis_tvalid && s_axis_tready) begin
                build_frame_results(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8],
                                    s_axis_tdata[23:16]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                seen.kind    = m_axis_tuser;
                seen.fbyte   = m_axis_tdata[BYTE_W-1:0];
                seen.last    = m_axis_tlast;
                seen.outcome = t_outcome'(m_axis_tdata[BYTE_W +: OUTCOME_W]);
                if (owed_results.size() == 0) begin
                    $display("%0t: result beat with nothing owed, expected none,", $time,
                             " got kind %0d byte 0x%02h last %0d outcome %0d",
                             seen.kind, seen.fbyte, seen.last, seen.outcome);
                    o_fail_count++;
                end else begin
                    want = owed_results.pop_front();
                    if (seen !== want) begin
                        $display("%0t: expected kind %0d byte 0x%02h last %0d outcome %0d,",
                                 $time, want.kind, want.fbyte, want.last, want.outcome,
                                 " got kind %0d byte 0x%02h last %0d outcome %0d",
                                 seen.kind, seen.fbyte, seen.last, seen.outcome);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = owed_results.size();
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import fwfb_pkg::*;

    // index with no register behind it, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    // image bytes and replies of the random part
    localparam int RANDOM_ITEMS = 230;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // image_byte, reply_code, write_status
    logic                   s_axis_tuser  = 1'b0; // opcode
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // frame_byte, outcome, zero pad
    logic                   m_axis_tuser;         // result_kind
    logic                   m_axis_tlast;         // last_of_run

    int fail_count;
    int pending;

    // image bytes and replies of well-formed transfers sent in the random part
    int image_items = 0;
    int phase;
    int roll;
    logic [BYTE_W-1:0] code_pick;

    // window of the random part in which neither side idles
    wire steady = (image_items >= 60) && (image_items < 130);

    // stimulus-side copies of the settings, used to shape the replies
    logic [COUNT_W-1:0] img_len    = '0;
    logic [ADDR_W-1:0]  cur_base   = BASE_ADDRESS_RST;
    logic [BYTE_W-1:0]  cur_opcode = '0;
    logic [BYTE_W-1:0]  cur_ack    = '0;
    logic [BYTE_W-1:0]  cur_nack   = '0;
    logic [BYTE_W-1:0]  cur_wfail  = '0;

    always #10 i_clk = ~i_clk;

    flash_write_frame_builder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    fwfb_checker frame_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // receiver back-pressure, roughly a quarter of the cycles stalled
    always @(posedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= 24);
    end

    // one input beat: random idle cycles first, then hold until taken
    task automatic push_beat(input logic op, input logic [BYTE_W-1:0] img,
                             input logic [BYTE_W-1:0] code, input logic [BYTE_W-1:0] status);
        while (!steady && $urandom_range(99) < 24) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {status, code, img};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // unused fields carry random bits so every tdata bit toggles
    task automatic push_image(input logic [BYTE_W-1:0] b);
        push_beat(OP_IMAGE, b, BYTE_W'($urandom), BYTE_W'($urandom));
    endtask

    task automatic push_reply(input logic [BYTE_W-1:0] code, input logic [BYTE_W-1:0] status);
        push_beat(OP_REPLY, BYTE_W'($urandom), code, status);
    endtask

    task automatic push_noise();
        push_beat(1'($urandom), BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
    endtask

    // sender stops until every owed result beat is out, then lets the block settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
    endtask

    // full register set, only ever while idle; length last so it restarts the image
    task automatic set_regs(input logic [COUNT_W-1:0] len, input logic [ADDR_W-1:0] base,
                            input logic [BYTE_W-1:0] opc, input logic [BYTE_W-1:0] ack,
                            input logic [BYTE_W-1:0] nack, input logic [BYTE_W-1:0] wfail);
        drain();
        write_reg(REG_BASE_ADDRESS, base);
        write_reg(REG_WRITE_OPCODE, CFG_DATA_W'(opc));
        write_reg(REG_ACK_CODE, CFG_DATA_W'(ack));
        write_reg(REG_NACK_CODE, CFG_DATA_W'(nack));
        write_reg(REG_WRITE_FAILED, CFG_DATA_W'(wfail));
        write_reg(REG_IMAGE_LENGTH, CFG_DATA_W'(len));
        i_cfg_we   <= 1'b0;
        img_len    = len;
        cur_base   = base;
        cur_opcode = opc;
        cur_ack    = ack;
        cur_nack   = nack;
        cur_wfail  = wfail;
    endtask

    // extremes weighted in
    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] good_status();
        logic [BYTE_W-1:0] st;
        st = BYTE_W'($urandom);
        if (st == cur_wfail) st = ~st;
        return st;
    endfunction

    // a reply code that is neither ack nor nack
    function automatic logic [BYTE_W-1:0] stray_code();
        logic [BYTE_W-1:0] c;
        do c = BYTE_W'($urandom); while (c == cur_ack || c == cur_nack);
        return c;
    endfunction

    // one image transfer, chunk by chunk, each chunk answered by a reply;
    // clean forces good acks, budget caps the image bytes sent
    task automatic run_image(input int budget, input bit clean);
        int left;
        int chunk;
        int pick;
        left = int'(img_len);
        while (left > 0) begin
            chunk = (left > CHUNK_BYTES) ? CHUNK_BYTES : left;
            for (int i = 0; i < chunk; i++) begin
                if (budget == 0) return;
                // stray reply mid-chunk, nothing awaited so it is turned away
                if ($urandom_range(99) < 4) push_reply(BYTE_W'($urandom), BYTE_W'($urandom));
                push_image(BYTE_W'($urandom));
                budget--;
                image_items++;
            end
            left -= chunk;
            pick = clean ? 0 : $urandom_range(99);
            image_items++;
            if (pick < 78) begin
                push_reply(cur_ack, good_status());
            end else if (pick < 93) begin
                // nack or failed write: abort, then a few beats that must be dropped
                if (pick < 86) push_reply(cur_nack, BYTE_W'($urandom));
                else push_reply(cur_ack, cur_wfail);
                push_noise();
                push_noise();
                return;
            end else begin
                // unknown reply closes the chunk, transfer carries on
                push_reply(stray_code(), BYTE_W'($urandom));
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset registers: zero-length image, so both kinds are turned away
        push_image(8'hFF);
        push_reply(8'hFF, 8'h00);

        // one-byte chunk, the longest run of result beats
        set_regs(24'd1, 32'h0000_0000, 8'hFF, 8'h11, 8'h22, 8'h33);
        push_image(8'hFF);
        push_image(8'h00);          // reply still owed
        push_reply(8'h11, 8'h00);   // ack, write ok, image complete
        push_reply(8'h11, 8'h00);   // nothing awaited any more
        push_image(8'h5A);          // whole image already sent

        // nack aborts, later beats of both kinds are dropped
        set_regs(24'd2, 32'h8000_0000, 8'h00, 8'h11, 8'h22, 8'h33);
        push_image(8'h00);
        push_image(8'h80);
        push_reply(8'h22, 8'hFF);
        push_image(8'h01);
        push_reply(8'h11, 8'h00);

        // ack carrying the failed-write status aborts as well
        set_regs(24'd2, 32'h0000_00FF, 8'h7E, 8'hFF, 8'h00, 8'hFF);
        push_image(8'hC3);
        push_image(8'h3C);
        push_reply(8'hFF, 8'hFF);

        // ack and nack codes equal: the ack test wins
        set_regs(24'd1, 32'h1234_5678, 8'h01, 8'h77, 8'h77, 8'h00);
        push_image(8'h7F);
        push_reply(8'h77, 8'h01);

        // unknown reply closes the chunk without an abort
        set_regs(24'd1, 32'hFFFF_FFFF, 8'h80, 8'h10, 8'h20, 8'h30);
        push_image(8'hA5);
        push_reply(8'h99, 8'h30);
        push_image(8'h5A);

        // base moved with a chunk open: the open transfer keeps its address
        set_regs(24'd3, 32'h0000_1000, 8'h31, 8'h01, 8'h02, 8'h03);
        push_image(8'h10);
        drain();
        write_reg(REG_BASE_ADDRESS, 32'h0000_2000);
        write_reg(REG_SPARE, 32'hFFFF_FFFF);
        i_cfg_we <= 1'b0;
        cur_base = 32'h0000_2000;
        push_image(8'h20);
        push_image(8'h30);
        push_reply(8'h01, 8'h00);
        // restart picks the moved base up
        set_regs(24'd1, cur_base, 8'h31, 8'h01, 8'h02, 8'h03);
        push_image(8'hEE);
        push_reply(8'h01, 8'h00);

        // random part: mostly short images, now and then several chunks
        phase = 0;
        while (image_items < RANDOM_ITEMS) begin
            if (phase == 0) begin
                // longest image from near the top of the address space: the
                // second frame header shows the wrapped address
                set_regs(24'hFF_FFFF, 32'hFFFF_FFC0, pick_byte(), 8'h5C, 8'hC5, 8'h00);
                run_image(140, 1'b1);
            end else if (phase == 1) begin
                // empty image, everything turned away
                set_regs('0, 32'hFFFF_FFFF, pick_byte(), pick_byte(), pick_byte(), pick_byte());
                repeat (4) push_noise();
            end else begin
                roll      = $urandom_range(99);
                code_pick = pick_byte();
                set_regs((roll < 15) ? COUNT_W'($urandom_range(260, 129))
                                     : COUNT_W'($urandom_range(24, 1)),
                         ($urandom_range(2) == 0) ? 32'h0000_0000
                       : ($urandom_range(1) == 0) ? 32'hFFFF_FFFF : ADDR_W'($urandom),
                         pick_byte(), code_pick,
                         ($urandom_range(9) == 0) ? code_pick : pick_byte(),
                         pick_byte());
                // the last image may be cut short so the item count stays near the target
                run_image(RANDOM_ITEMS - image_items, 1'b0);
            end
            phase++;
        end

        drain();
        @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #4ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
